// ----- rtl/armpd_pkg.sv -----
// Shared types, constants and helpers for the arm position PD controller.
`default_nettype none

package armpd_pkg;

   localparam int ANGLE_BITS_DEFAULT = 24;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KP_FAR      = 3'd0,
      CSR_KP_NEAR     = 3'd1,
      CSR_KD          = 3'd2,
      CSR_NEAR_BAND   = 3'd3,
      CSR_SETTLE_BAND = 3'd4,
      CSR_SETTLE_TICKS = 3'd5,
      CSR_CMD_LIMIT   = 3'd6
   } armpd_csr_index_type;

   typedef struct packed {
      logic [11:0] kp_far_q8;
      logic [11:0] kp_near_q8;
      logic [11:0] kd_q8;
      logic [15:0] near_band_cd;
      logic [15:0] settle_band_cd;
      logic [3:0]  settle_ticks;
      logic [6:0]  command_limit;
   } armpd_csr_type;

   localparam logic [11:0] KP_FAR_RESET       = 12'd1101;
   localparam logic [11:0] KP_NEAR_RESET      = 12'd1280;
   localparam logic [11:0] KD_RESET           = 12'd973;
   localparam logic [15:0] NEAR_BAND_RESET    = 16'd500;
   localparam logic [15:0] SETTLE_BAND_RESET  = 16'd100;
   localparam logic [3:0]  SETTLE_TICKS_RESET = 4'd10;
   localparam logic [6:0]  CMD_LIMIT_RESET    = 7'd100;

   // Control fields carried alongside the datapath
   typedef struct packed {
      logic       closed_loop;
      logic [1:0] preset_step;
      logic [7:0] stick_value;
   } armpd_ctrl_type;

   localparam logic [14:0] TARGET_R1 = 15'd3000;
   localparam logic [14:0] TARGET_R2 = 15'd700;

   // PD output scale: acc / 25600 = (acc >> 10) / 25
   localparam int PD_DIVISOR      = 25600;
   localparam int PD_DIV_SHIFT    = 10;
   localparam int PD_RECIP        = 2622;
   localparam int PD_RECIP_SHIFT  = 16;
   // Manual scale: stick * 100 / 127 as (|stick| * 825700) >> 20
   localparam int MAN_RECIP       = 825700;
   localparam int MAN_RECIP_SHIFT = 20;

   function automatic logic [14:0] preset_target(input logic [1:0] step);
      logic [14:0] t;
      case (step)
         2'd0: t = 15'd8000;
         2'd1: t = 15'd16800;
         2'd2: t = 15'd17200;
         2'd3: t = 15'd18400;
         default: t = 15'd8000;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/armpd_front.sv -----
// Input register, button/target state, error and PD product stage.
`default_nettype none

module armpd_front import armpd_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
   localparam int EW = ANGLE_BITS + 1,
   localparam int DW = ANGLE_BITS + 2,
   localparam int PW = DW + 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire armpd_csr_type         csr,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_r1_button,
   input  wire logic                  req_r2_button,
   input  wire logic                  req_step_button,
   input  wire logic signed [7:0]     req_stick_value,
   input  wire logic signed [ANGLE_BITS-1:0] req_angle_cd,
   input  wire logic                  down_ready,
   output logic                       s1_valid,
   output armpd_ctrl_type             s1_ctrl,
   output logic signed [PW-1:0]       s1_p_prod,
   output logic signed [PW-1:0]       s1_d_prod
);

   logic                  s0_valid_ff, s0_valid_in;
   logic                  s0_r1_ff, s0_r2_ff, s0_step_ff;
   logic [7:0]            s0_stick_ff;
   logic [ANGLE_BITS-1:0] s0_angle_ff;

   logic                  s1_valid_ff, s1_valid_in;
   armpd_ctrl_type        s1_ctrl_ff, s1_ctrl_in;
   logic signed [PW-1:0]  s1_p_ff, s1_p_in;
   logic signed [PW-1:0]  s1_d_ff, s1_d_in;

   logic                  loop_active_ff, loop_active_in;
   logic [14:0]           target_ff, target_in;
   logic [1:0]            cycle_step_ff, cycle_step_in;
   logic [1:0]            saved_step_ff, saved_step_in;
   logic                  step_held_ff, step_held_in;
   logic [3:0]            settle_count_ff, settle_count_in;
   logic signed [EW-1:0]  last_error_ff, last_error_in;

   logic                  s1_free, s0_move, req_fire;
   logic                  closed_v;
   logic signed [EW-1:0]  err;
   logic [EW-1:0]         abs_err;
   logic signed [DW-1:0]  diff;
   logic signed [12:0]    kp_s, kd_s;
   logic signed [EW+12:0] p_full;
   logic signed [PW-1:0]  d_full;

   assign s1_free   = !s1_valid_ff || down_ready;
   assign s0_move   = s0_valid_ff && s1_free;
   assign req_stall = s0_valid_ff && !s1_free;
   assign req_fire  = req_valid && !req_stall;

   assign s0_valid_in = req_fire || (s0_valid_ff && !s1_free);
   assign s1_valid_in = s0_move || (s1_valid_ff && !down_ready);

   always_comb begin
      loop_active_in  = loop_active_ff;
      target_in       = target_ff;
      cycle_step_in   = cycle_step_ff;
      saved_step_in   = saved_step_ff;
      step_held_in    = step_held_ff;
      settle_count_in = settle_count_ff;
      last_error_in   = last_error_ff;

      if (s0_r1_ff) begin
         cycle_step_in  = saved_step_in;
         loop_active_in = 1'b1;
         target_in      = TARGET_R1;
      end
      if (s0_r2_ff) begin
         cycle_step_in  = saved_step_in;
         loop_active_in = 1'b1;
         target_in      = TARGET_R2;
      end
      if (s0_step_ff) begin
         if (!step_held_ff) begin
            step_held_in   = 1'b1;
            saved_step_in  = cycle_step_in;
            loop_active_in = 1'b1;
            target_in      = preset_target(cycle_step_in);
            cycle_step_in  = cycle_step_in + 2'd1;
         end
      end else begin
         step_held_in = 1'b0;
      end

      closed_v = loop_active_in;
      err      = $signed({{(EW-15){1'b0}}, target_in})
                 - $signed({s0_angle_ff[ANGLE_BITS-1], s0_angle_ff});
      abs_err  = err[EW-1] ? EW'(-err) : EW'(err);
      diff     = $signed({err[EW-1], err}) - $signed({last_error_ff[EW-1], last_error_ff});
      kp_s     = (abs_err < {{(EW-16){1'b0}}, csr.near_band_cd})
                 ? $signed({1'b0, csr.kp_near_q8}) : $signed({1'b0, csr.kp_far_q8});
      kd_s     = $signed({1'b0, csr.kd_q8});
      p_full   = err * kp_s;
      d_full   = diff * kd_s;

      if (loop_active_in) begin
         last_error_in = err;
         if (abs_err < {{(EW-16){1'b0}}, csr.settle_band_cd}) begin
            settle_count_in = settle_count_ff + 4'd1;
            if (settle_count_in == csr.settle_ticks) begin
               loop_active_in  = 1'b0;
               last_error_in   = '0;
               settle_count_in = 4'd1;
            end
         end else begin
            settle_count_in = 4'd1;
         end
      end

      s1_ctrl_in.closed_loop = closed_v;
      s1_ctrl_in.preset_step = cycle_step_in;
      s1_ctrl_in.stick_value = s0_stick_ff;
      s1_p_in = {p_full[EW+12], p_full};
      s1_d_in = d_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         loop_active_ff  <= 1'b0;
         target_ff       <= '0;
         cycle_step_ff   <= '0;
         saved_step_ff   <= '0;
         step_held_ff    <= 1'b0;
         settle_count_ff <= 4'd1;
         last_error_ff   <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         if (s0_move) begin
            loop_active_ff  <= loop_active_in;
            target_ff       <= target_in;
            cycle_step_ff   <= cycle_step_in;
            saved_step_ff   <= saved_step_in;
            step_held_ff    <= step_held_in;
            settle_count_ff <= settle_count_in;
            last_error_ff   <= last_error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_r1_ff    <= req_r1_button;
         s0_r2_ff    <= req_r2_button;
         s0_step_ff  <= req_step_button;
         s0_stick_ff <= req_stick_value;
         s0_angle_ff <= req_angle_cd;
      end
      if (s0_move) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_p_ff    <= s1_p_in;
         s1_d_ff    <= s1_d_in;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_ctrl   = s1_ctrl_ff;
   assign s1_p_prod = s1_p_ff;
   assign s1_d_prod = s1_d_ff;

endmodule

`default_nettype wire

// ----- rtl/armpd_back.sv -----
// PD sum, output scaling and saturation, result register.
`default_nettype none

module armpd_back import armpd_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
   localparam int PW = ANGLE_BITS + 15,
   localparam int AW = PW + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire armpd_csr_type        csr,
   input  wire logic                 s1_valid,
   input  wire armpd_ctrl_type       s1_ctrl,
   input  wire logic signed [PW-1:0] s1_p_prod,
   input  wire logic signed [PW-1:0] s1_d_prod,
   output logic                      down_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [7:0]         rsp_velocity_command,
   output logic                      rsp_closed_loop,
   output logic [1:0]                rsp_preset_step
);

   logic                 s2_valid_ff, s2_valid_in;
   armpd_ctrl_type       s2_ctrl_ff;
   logic signed [AW-1:0] s2_acc_ff, s2_acc_in;

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_cmd_ff, out_cmd_in;
   logic                 out_closed_ff;
   logic [1:0]           out_step_ff;

   logic                 out_free, s2_free, s2_move, s1_move;
   logic [AW-1:0]        mag;
   logic [21:0]          thresh;
   logic [11:0]          quot_in;
   logic [23:0]          pd_prod;
   logic [6:0]           pd_mag;
   logic [7:0]           stick_mag;
   logic [27:0]          man_prod;
   logic [6:0]           man_mag;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s2_move    = s2_valid_ff && out_free;
   assign s1_move    = s1_valid && s2_free;
   assign down_ready = s2_free;

   assign s2_valid_in  = s1_move || (s2_valid_ff && !out_free);
   assign out_valid_in = s2_move || (out_valid_ff && rsp_stall);
   assign s2_acc_in    = $signed({s1_p_prod[PW-1], s1_p_prod})
                         + $signed({s1_d_prod[PW-1], s1_d_prod});

   always_comb begin
      mag       = s2_acc_ff[AW-1] ? AW'(-s2_acc_ff) : AW'(s2_acc_ff);
      thresh    = {15'd0, csr.command_limit} * 22'(PD_DIVISOR);
      quot_in   = mag[PD_DIV_SHIFT +: 12];
      pd_prod   = {12'd0, quot_in} * 24'(PD_RECIP);
      pd_mag    = (mag >= {{(AW-22){1'b0}}, thresh})
                  ? csr.command_limit : pd_prod[PD_RECIP_SHIFT +: 7];
      stick_mag = s2_ctrl_ff.stick_value[7] ? 8'(-s2_ctrl_ff.stick_value)
                                            : s2_ctrl_ff.stick_value;
      man_prod  = {20'd0, stick_mag} * 28'(MAN_RECIP);
      man_mag   = man_prod[MAN_RECIP_SHIFT +: 7];
      if (s2_ctrl_ff.closed_loop) begin
         out_cmd_in = s2_acc_ff[AW-1] ? 8'(-{1'b0, pd_mag}) : {1'b0, pd_mag};
      end else begin
         out_cmd_in = s2_ctrl_ff.stick_value[7] ? 8'(-{1'b0, man_mag}) : {1'b0, man_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ctrl_ff <= s1_ctrl;
         s2_acc_ff  <= s2_acc_in;
      end
      if (s2_move) begin
         out_cmd_ff    <= out_cmd_in;
         out_closed_ff <= s2_ctrl_ff.closed_loop;
         out_step_ff   <= s2_ctrl_ff.preset_step;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_velocity_command = out_cmd_ff;
   assign rsp_closed_loop      = out_closed_ff;
   assign rsp_preset_step      = out_step_ff;

endmodule

`default_nettype wire

// ----- rtl/arm_position_pd_with_presets.sv -----
// Top level of the arm position PD controller with presets and register file.
//
//   port group  direction  flow control         content
//   req_*       in         req_valid/req_stall  buttons, stick, measured angle
//   rsp_*       out        rsp_valid/rsp_stall  velocity command, loop flag, preset step
//   csr_*       in         csr_write_enable     register index and write data
//
// One transaction per cycle sustained while rsp_stall is low; each transaction passes
// through the input register, error/product stage, sum stage, scaling/result register.
// The target and settle state update as a transaction leaves the input register.
// Reset is synchronous; valid flags, loop state and CSRs return to their reset values.
// rsp_stall holds the result register and backs up the stages to req_stall.
`default_nettype none

module arm_position_pd_with_presets import armpd_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_r1_button,
   input  wire logic                         req_r2_button,
   input  wire logic                         req_step_button,
   input  wire logic signed [7:0]            req_stick_value,
   input  wire logic signed [ANGLE_BITS-1:0] req_angle_cd,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [7:0]                 rsp_velocity_command,
   output logic                              rsp_closed_loop,
   output logic [1:0]                        rsp_preset_step
);

   localparam int PW = ANGLE_BITS + 15;

   armpd_csr_type        csr_ff, csr_in;
   logic                 s1_valid, down_ready;
   armpd_ctrl_type       s1_ctrl;
   logic signed [PW-1:0] s1_p_prod, s1_d_prod;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (armpd_csr_index_type'(csr_index))
            CSR_KP_FAR:       csr_in.kp_far_q8      = csr_write_data[11:0];
            CSR_KP_NEAR:      csr_in.kp_near_q8     = csr_write_data[11:0];
            CSR_KD:           csr_in.kd_q8          = csr_write_data[11:0];
            CSR_NEAR_BAND:    csr_in.near_band_cd   = csr_write_data;
            CSR_SETTLE_BAND:  csr_in.settle_band_cd = csr_write_data;
            CSR_SETTLE_TICKS: csr_in.settle_ticks   = csr_write_data[3:0];
            CSR_CMD_LIMIT:    csr_in.command_limit  = csr_write_data[6:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.kp_far_q8      <= KP_FAR_RESET;
         csr_ff.kp_near_q8     <= KP_NEAR_RESET;
         csr_ff.kd_q8          <= KD_RESET;
         csr_ff.near_band_cd   <= NEAR_BAND_RESET;
         csr_ff.settle_band_cd <= SETTLE_BAND_RESET;
         csr_ff.settle_ticks   <= SETTLE_TICKS_RESET;
         csr_ff.command_limit  <= CMD_LIMIT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   armpd_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_r1_button   (req_r1_button),
      .req_r2_button   (req_r2_button),
      .req_step_button (req_step_button),
      .req_stick_value (req_stick_value),
      .req_angle_cd    (req_angle_cd),
      .down_ready      (down_ready),
      .s1_valid        (s1_valid),
      .s1_ctrl         (s1_ctrl),
      .s1_p_prod       (s1_p_prod),
      .s1_d_prod       (s1_d_prod)
   );

   armpd_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .csr                  (csr_ff),
      .s1_valid             (s1_valid),
      .s1_ctrl              (s1_ctrl),
      .s1_p_prod            (s1_p_prod),
      .s1_d_prod            (s1_d_prod),
      .down_ready           (down_ready),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_velocity_command (rsp_velocity_command),
      .rsp_closed_loop      (rsp_closed_loop),
      .rsp_preset_step      (rsp_preset_step)
   );

endmodule

`default_nettype wire
